/* sv/t16dec_pkg.sv */
// Package for the Thumb 16-bit instruction decoder.
// Holds operation codes, shared widths and the front-to-back item struct.
// No dependencies.
package t16dec_pkg;

   localparam int QueueDepth = 2;
   localparam int OutDepth = 2;

   typedef enum logic [6:0] {
      OP_UNDEF = 7'd0, OP_LSL_I = 7'd1, OP_LSR_I = 7'd2, OP_ASR_I = 7'd3,
      OP_ADD_R = 7'd4, OP_SUB_R = 7'd5, OP_ADD_I3 = 7'd6, OP_SUB_I3 = 7'd7,
      OP_MOV_I8 = 7'd8, OP_ALU_BASE = 7'd12, OP_ADD_HI = 7'd28, OP_CMP_HI = 7'd29,
      OP_MOV_HI = 7'd30, OP_CPY = 7'd31, OP_BX = 7'd32, OP_BLX_R = 7'd33,
      OP_LDR_PC = 7'd34, OP_LDST_R = 7'd35, OP_STR_I = 7'd43, OP_LDR_I = 7'd44,
      OP_STRB_I = 7'd45, OP_LDRB_I = 7'd46, OP_STRH_I = 7'd47, OP_LDRH_I = 7'd48,
      OP_STR_SP = 7'd49, OP_LDR_SP = 7'd50, OP_ADD_PC = 7'd51, OP_ADD_RSP = 7'd52,
      OP_ADD_SP = 7'd53, OP_SUB_SP = 7'd54, OP_EXT_BASE = 7'd55, OP_PUSH = 7'd59,
      OP_SETEND_LE = 7'd60, OP_SETEND_BE = 7'd61, OP_CPSIE = 7'd62, OP_CPSID = 7'd63,
      OP_REV = 7'd64, OP_REV16 = 7'd65, OP_REVSH = 7'd66, OP_POP = 7'd67,
      OP_BKPT = 7'd68, OP_STMIA = 7'd69, OP_LDMIA = 7'd70, OP_BCOND = 7'd71,
      OP_SWI = 7'd72, OP_B = 7'd73, OP_BLX_SUF = 7'd74, OP_BL_PRE = 7'd75,
      OP_BL_SUF = 7'd76
   } op_type;

   localparam logic [3:0] CondAl = 4'd14;
   localparam logic [3:0] RegSp = 4'd13;
   localparam logic [3:0] RegLr = 4'd14;
   localparam logic [3:0] RegPc = 4'd15;

   // Target kinds the back end computes
   typedef enum logic [2:0] {
      TGT_NONE, TGT_COND, TGT_UNCOND, TGT_PREFIX, TGT_BLX, TGT_BL
   } tgt_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic [6:0]  operation;
      logic [3:0]  dest_reg;
      logic [3:0]  first_src_reg;
      logic [3:0]  second_src_reg;
      logic [9:0]  immediate_value;
      logic [3:0]  condition_code;
      logic [8:0]  register_list;
      tgt_type     kind;
      logic [10:0] offset;
      logic [31:0] pc;
   } item_type;

   typedef struct packed {
      logic [6:0]  operation;
      logic [3:0]  dest_reg;
      logic [3:0]  first_src_reg;
      logic [3:0]  second_src_reg;
      logic [9:0]  immediate_value;
      logic [3:0]  condition_code;
      logic [8:0]  register_list;
      logic [31:0] branch_target;
   } result_type;

endpackage

/* sv/t16dec_front.sv */
// Front end: classifies one halfword into operation and register fields.
// Tracks the BL/BLX prefix flag. Depends on t16dec_pkg.
module t16dec_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [15:0]           hw,
   input  logic [31:0]           addr,
   output t16dec_pkg::item_type  item
);

   logic prefix_ff, prefix_in;

   // Decode
   always_comb begin
      logic [6:0] op;
      logic [3:0] rd, rn, rm, lo, mid, hi3, hd, hm;
      logic [9:0] imm;
      logic [3:0] cnd;
      logic [8:0] lst;
      logic [4:0] imm5;
      logic [2:0] sub;
      logic [1:0] k;
      t16dec_pkg::tgt_type kind;
      op = t16dec_pkg::OP_UNDEF;
      rd = '0; rn = '0; rm = '0; imm = '0; cnd = t16dec_pkg::CondAl; lst = '0;
      kind = t16dec_pkg::TGT_NONE;
      lo = {1'b0, hw[2:0]}; mid = {1'b0, hw[5:3]}; hi3 = {1'b0, hw[10:8]};
      hd = {hw[7], hw[2:0]}; hm = hw[6:3]; imm5 = hw[10:6];
      sub = hw[7:5]; k = hw[7:6];
      case (hw[15:12])
         4'h0: begin
            op = hw[11] ? t16dec_pkg::OP_LSR_I : t16dec_pkg::OP_LSL_I;
            rd = lo; rn = mid; imm = {5'd0, imm5};
            if (hw[11] && imm5 == 5'd0) imm = 10'd32;
         end
         4'h1: begin
            rd = lo; rn = mid;
            if (!hw[11]) begin
               op = t16dec_pkg::OP_ASR_I;
               imm = (imm5 != 5'd0) ? {5'd0, imm5} : 10'd32;
            end else if (hw[10]) begin
               op = hw[9] ? t16dec_pkg::OP_SUB_I3 : t16dec_pkg::OP_ADD_I3;
               imm = {7'd0, hw[8:6]};
            end else begin
               op = hw[9] ? t16dec_pkg::OP_SUB_R : t16dec_pkg::OP_ADD_R;
               rm = {1'b0, hw[8:6]};
            end
         end
         4'h2, 4'h3: begin
            op = t16dec_pkg::OP_MOV_I8 + {5'd0, hw[12], hw[11]};
            rd = hi3; rn = hi3; imm = {2'd0, hw[7:0]};
         end
         4'h4: begin
            if (hw[11]) begin
               op = t16dec_pkg::OP_LDR_PC; rd = hi3; rn = t16dec_pkg::RegPc;
               imm = {hw[7:0], 2'b00};
            end else if (!hw[10]) begin
               op = t16dec_pkg::OP_ALU_BASE + {3'd0, hw[9:6]};
               rd = lo; rn = lo; rm = mid;
            end else begin
               case (hw[9:8])
                  2'd0, 2'd1: begin
                     if (hw[7:6] != 2'd0) begin
                        op = hw[8] ? t16dec_pkg::OP_CMP_HI : t16dec_pkg::OP_ADD_HI;
                        rd = hd; rn = hd; rm = hm;
                     end
                  end
                  2'd2: begin
                     op = (hw[7:6] != 2'd0) ? t16dec_pkg::OP_MOV_HI : t16dec_pkg::OP_CPY;
                     rd = hd; rn = hm;
                  end
                  default: begin
                     op = hw[7] ? t16dec_pkg::OP_BLX_R : t16dec_pkg::OP_BX;
                     rn = hm;
                     if (hw[7]) rd = t16dec_pkg::RegLr;
                  end
               endcase
            end
         end
         4'h5: begin
            op = t16dec_pkg::OP_LDST_R + {4'd0, hw[11:9]};
            rd = lo; rn = mid; rm = {1'b0, hw[8:6]};
         end
         4'h6: begin
            op = hw[11] ? t16dec_pkg::OP_LDR_I : t16dec_pkg::OP_STR_I;
            rd = lo; rn = mid; imm = {3'd0, imm5, 2'b00};
         end
         4'h7: begin
            op = hw[11] ? t16dec_pkg::OP_LDRB_I : t16dec_pkg::OP_STRB_I;
            rd = lo; rn = mid; imm = {5'd0, imm5};
         end
         4'h8: begin
            op = hw[11] ? t16dec_pkg::OP_LDRH_I : t16dec_pkg::OP_STRH_I;
            rd = lo; rn = mid; imm = {4'd0, imm5, 1'b0};
         end
         4'h9: begin
            op = hw[11] ? t16dec_pkg::OP_LDR_SP : t16dec_pkg::OP_STR_SP;
            rd = hi3; rn = t16dec_pkg::RegSp; imm = {hw[7:0], 2'b00};
         end
         4'ha: begin
            op = hw[11] ? t16dec_pkg::OP_ADD_RSP : t16dec_pkg::OP_ADD_PC;
            rd = hi3; rn = hw[11] ? t16dec_pkg::RegSp : t16dec_pkg::RegPc;
            imm = {hw[7:0], 2'b00};
         end
         4'hb: begin
            case (hw[11:8])
               4'h0: begin
                  op = hw[7] ? t16dec_pkg::OP_SUB_SP : t16dec_pkg::OP_ADD_SP;
                  rd = t16dec_pkg::RegSp; rn = t16dec_pkg::RegSp;
                  imm = {1'b0, hw[6:0], 2'b00};
               end
               4'h2: begin
                  op = t16dec_pkg::OP_EXT_BASE + {5'd0, hw[7:6]}; rd = lo; rn = mid;
               end
               4'h4, 4'h5: begin
                  op = t16dec_pkg::OP_PUSH; rd = t16dec_pkg::RegSp;
                  rn = t16dec_pkg::RegSp; lst = hw[8:0];
               end
               4'h6: begin
                  if (sub == 3'd2) begin
                     op = hw[3] ? t16dec_pkg::OP_SETEND_BE : t16dec_pkg::OP_SETEND_LE;
                  end else if (sub == 3'd3) begin
                     op = hw[4] ? t16dec_pkg::OP_CPSID : t16dec_pkg::OP_CPSIE;
                     imm = {7'd0, hw[2:0]};
                  end
               end
               4'ha: begin
                  if (k != 2'd2) begin
                     op = (k == 2'd3) ? t16dec_pkg::OP_REVSH
                                      : t16dec_pkg::OP_REV + {5'd0, k};
                     rd = lo; rn = mid;
                  end
               end
               4'hc, 4'hd: begin
                  op = t16dec_pkg::OP_POP; rd = t16dec_pkg::RegSp;
                  rn = t16dec_pkg::RegSp; lst = hw[8:0];
               end
               4'he: begin
                  op = t16dec_pkg::OP_BKPT; imm = {2'd0, hw[7:0]};
               end
               default: ;
            endcase
         end
         4'hc: begin
            op = hw[11] ? t16dec_pkg::OP_LDMIA : t16dec_pkg::OP_STMIA;
            rd = hi3; rn = hi3; lst = {1'b0, hw[7:0]};
         end
         4'hd: begin
            if (hw[11:8] < 4'd14) begin
               op = t16dec_pkg::OP_BCOND; cnd = hw[11:8]; kind = t16dec_pkg::TGT_COND;
            end else if (hw[11:8] == 4'd15) begin
               op = t16dec_pkg::OP_SWI; imm = {2'd0, hw[7:0]};
            end
         end
         4'he: begin
            if (!hw[11]) begin
               op = t16dec_pkg::OP_B; kind = t16dec_pkg::TGT_UNCOND;
            end else if (prefix_ff && !hw[0]) begin
               op = t16dec_pkg::OP_BLX_SUF; rd = t16dec_pkg::RegLr;
               kind = t16dec_pkg::TGT_BLX;
            end
         end
         default: begin
            if (!hw[11]) begin
               op = t16dec_pkg::OP_BL_PRE; rd = t16dec_pkg::RegLr;
               kind = t16dec_pkg::TGT_PREFIX;
            end else if (prefix_ff) begin
               op = t16dec_pkg::OP_BL_SUF; rd = t16dec_pkg::RegLr;
               kind = t16dec_pkg::TGT_BL;
            end
         end
      endcase
      if (op == t16dec_pkg::OP_UNDEF) begin
         rd = '0; rn = '0; rm = '0; imm = '0; cnd = '0; lst = '0;
      end
      item.operation       = op;
      item.dest_reg        = rd;
      item.first_src_reg   = rn;
      item.second_src_reg  = rm;
      item.immediate_value = imm;
      item.condition_code  = cnd;
      item.register_list   = lst;
      item.kind            = kind;
      item.offset          = hw[10:0];
      item.pc              = addr + 32'd4;
   end

   // Prefix flag: set by an accepted prefix, cleared by any other accepted halfword
   assign prefix_in = take ? (hw[15:11] == 5'b11110) : prefix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
      end
   end

endmodule

/* sv/t16dec_queue.sv */
// Small synchronous FIFO used between stages and at the output.
// Depends on nothing but its parameters.
module t16dec_queue #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);

   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [AddrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full = (cnt_ff == CntW'(Depth));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AddrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AddrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   cnt_bound_a: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(Depth)) else $error("queue count overflow");
   no_pop_empty_a: assert property (@(posedge clock) disable iff (reset)
      empty |=> !(cnt_ff == CntW'(Depth) && Depth > 1)) else $error("queue jump");
   push_grow_a: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty) else $error("push lost");

endmodule

/* sv/t16dec_back.sv */
// Back end: computes branch targets and holds the BL/BLX link base.
// Depends on t16dec_pkg.
module t16dec_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  t16dec_pkg::item_type    item,
   output t16dec_pkg::result_type  res
);

   logic [31:0] base_ff, base_in;
   logic [31:0] tgt;
   logic [31:0] prefix_base;

   // Prefix base: pc plus the sign-extended offset shifted up by twelve
   assign prefix_base = item.pc + {{9{item.offset[10]}}, item.offset, 12'd0};

   // Target selection
   always_comb begin
      case (item.kind)
         t16dec_pkg::TGT_COND:
            tgt = item.pc + {{23{item.offset[7]}}, item.offset[7:0], 1'b0};
         t16dec_pkg::TGT_UNCOND:
            tgt = item.pc + {{20{item.offset[10]}}, item.offset, 1'b0};
         t16dec_pkg::TGT_PREFIX: tgt = prefix_base;
         t16dec_pkg::TGT_BLX:
            tgt = (base_ff + {20'd0, item.offset, 1'b0}) & ~32'd3;
         t16dec_pkg::TGT_BL: tgt = base_ff + {20'd0, item.offset, 1'b0};
         default: tgt = '0;
      endcase
   end

   assign base_in = (take && item.kind == t16dec_pkg::TGT_PREFIX) ? prefix_base : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   assign res.operation       = item.operation;
   assign res.dest_reg        = item.dest_reg;
   assign res.first_src_reg   = item.first_src_reg;
   assign res.second_src_reg  = item.second_src_reg;
   assign res.immediate_value = item.immediate_value;
   assign res.condition_code  = item.condition_code;
   assign res.register_list   = item.register_list;
   assign res.branch_target   = tgt;

endmodule

/* sv/thumb16_instruction_decoder_core.sv */
// Thumb 16-bit decoder: front classifier, two-entry item queue, back end
// for targets and link base, two-entry result queue.
// Flow: an accepted item enters the item queue, then passes the back end
// into the result queue; one item per cycle while the result queue has room.
// Reset (synchronous, active high) empties both queues and clears the prefix
// flag and link base.
module thumb16_instruction_decoder_core #(
   parameter int QDepth = t16dec_pkg::QueueDepth,
   parameter int ODepth = t16dec_pkg::OutDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_instruction_halfword,
   input  logic [31:0] req_instruction_address,
   output logic        empty,
   input  logic        pop,
   output logic [6:0]  rsp_operation,
   output logic [3:0]  rsp_dest_reg,
   output logic [3:0]  rsp_first_src_reg,
   output logic [3:0]  rsp_second_src_reg,
   output logic [9:0]  rsp_immediate_value,
   output logic [3:0]  rsp_condition_code,
   output logic [8:0]  rsp_register_list,
   output logic [31:0] rsp_branch_target,
   output logic        rsp_is_undefined
);

   t16dec_pkg::item_type   f_item, b_item;
   t16dec_pkg::result_type b_res, o_res;
   logic take, q_empty, o_full, mv;

   assign take = push && !full;
   assign mv = !q_empty && !o_full;

   t16dec_front u_front (
      .clock(clock), .reset(reset), .take(take),
      .hw(req_instruction_halfword), .addr(req_instruction_address), .item(f_item));

   t16dec_queue #(.Width($bits(t16dec_pkg::item_type)), .Depth(QDepth)) u_iq (
      .clock(clock), .reset(reset), .push(push), .push_data(f_item), .full(full),
      .pop(mv), .pop_data(b_item), .empty(q_empty));

   t16dec_back u_back (
      .clock(clock), .reset(reset), .take(mv), .item(b_item), .res(b_res));

   t16dec_queue #(.Width($bits(t16dec_pkg::result_type)), .Depth(ODepth)) u_oq (
      .clock(clock), .reset(reset), .push(mv), .push_data(b_res), .full(o_full),
      .pop(pop), .pop_data(o_res), .empty(empty));

   assign rsp_operation       = o_res.operation;
   assign rsp_dest_reg        = o_res.dest_reg;
   assign rsp_first_src_reg   = o_res.first_src_reg;
   assign rsp_second_src_reg  = o_res.second_src_reg;
   assign rsp_immediate_value = o_res.immediate_value;
   assign rsp_condition_code  = o_res.condition_code;
   assign rsp_register_list   = o_res.register_list;
   assign rsp_branch_target   = o_res.branch_target;
   assign rsp_is_undefined    = (o_res.operation == t16dec_pkg::OP_UNDEF);

   undef_clean_a: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_is_undefined) |-> (rsp_branch_target == '0 && rsp_dest_reg == '0))
      else $error("undefined result carries fields");
   cond_only_bcond_a: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_condition_code != t16dec_pkg::CondAl && !rsp_is_undefined)
      |-> rsp_operation == t16dec_pkg::OP_BCOND) else $error("stray condition");
   move_a: assert property (@(posedge clock) disable iff (reset)
      mv |=> !empty) else $error("result lost");

endmodule
